FILE: sv/asrp_pkg.sv
// Shared types, character codes and helper functions for the ASCII sensor
// record parser. No dependencies.
`default_nettype none

package asrp_pkg;

  localparam int unsigned POS_W    = 4;
  localparam int unsigned CODE_W   = 7;
  localparam int unsigned MANT_W   = 24;
  localparam int unsigned VALUE_W  = 25;
  localparam int unsigned FRAC_W   = 3;

  // Frame layout: byte 0 ignored, code in bytes 1-2, value field from byte 3
  localparam logic [POS_W-1:0] CODE_FIRST  = 4'd1;
  localparam logic [POS_W-1:0] CODE_LAST   = 4'd2;
  localparam logic [POS_W-1:0] VALUE_FIRST = 4'd3;

  localparam logic [CODE_W-1:0] MAX_CODE_RST = 7'd22;
  localparam logic [CODE_W-1:0] CODE_SAT     = 7'd127;
  localparam logic [MANT_W-1:0] MANT_SAT     = 24'hFF_FFFF;
  localparam logic [FRAC_W-1:0] FRAC_MAX     = 3'd7;

  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_POINT = 8'h2E;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CODE  = 2'd1,
    ST_NO_NUMBER = 2'd2
  } status_e;

  // Next-state view of the code field parser
  typedef struct packed {
    logic [CODE_W-1:0] acc;
    logic              neg;
  } code_t;

  // Next-state view of the value field parser
  typedef struct packed {
    logic [MANT_W-1:0] mant;
    logic [FRAC_W-1:0] frac;
    logic              neg;
    logic              digit;
  } value_t;

  function automatic logic is_white(input logic [7:0] b);
    return (b == CHR_SPACE) || (b >= CHR_TAB && b <= CHR_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_NINE);
  endfunction

endpackage

`default_nettype wire

FILE: sv/asrp_if.sv
// Valid/ready channel interfaces: received bytes in, parsed records out.
// Depends on asrp_pkg.
`default_nettype none

interface asrp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface asrp_rec_if;
  import asrp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CODE_W-1:0]          channel_code;
  logic signed [VALUE_W-1:0]  value_mantissa;
  logic [FRAC_W-1:0]          fraction_digits;
  status_e                    status;

  modport source (output valid, output channel_code, output value_mantissa,
                  output fraction_digits, output status, input ready);
  modport sink   (input valid, input channel_code, input value_mantissa,
                  input fraction_digits, input status, output ready);
endinterface

`default_nettype wire

FILE: sv/ascii_sensor_record_parser.sv
// rec_o.valid is set when a frame's last byte moves from the input register on.
// Throughput: one byte per cycle; the input register holds a frame's last byte
// only while an earlier record is still waiting at the output register.
// One record per FRAME_BYTES bytes. Reset (async, active low) clears the frame
// position, both field parsers and the output valid; max_code returns to 22.
// Depends on asrp_pkg, asrp_if, asrp_code_field, asrp_value_field.
`default_nettype none

module ascii_sensor_record_parser #(
  parameter int unsigned FRAME_BYTES = 14,
  parameter int unsigned VALUE_CHARS = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    max_code_we_i,
  input  logic [asrp_pkg::CODE_W-1:0] max_code_i,
  asrp_byte_if.sink               rx_i,
  asrp_rec_if.source              rec_o
);
  import asrp_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] VALUE_END = POS_W'(VALUE_FIRST + VALUE_CHARS);

  logic [CODE_W-1:0]         max_code_q;
  logic                      in_valid_q;
  logic [7:0]                in_byte_q;
  logic [POS_W-1:0]          pos_q;
  logic                      last, advance, in_ready;
  logic                      code_en, value_en, frame_clr;
  code_t                     code_d;
  value_t                    value_d;
  logic                      bad_code;
  logic signed [VALUE_W-1:0] mant_signed;

  logic                      out_valid_q;
  logic [CODE_W-1:0]         code_q;
  logic signed [VALUE_W-1:0] mant_q;
  logic [FRAC_W-1:0]         frac_q;
  status_e                   status_q, status_d;

  assign last     = (pos_q == LAST_POS);
  // only the frame's last byte needs a free output register
  assign advance  = in_valid_q && !(last && out_valid_q && !rec_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign rx_i.ready = in_ready;

  assign code_en   = advance && pos_q >= CODE_FIRST && pos_q <= CODE_LAST;
  assign value_en  = advance && pos_q >= VALUE_FIRST && pos_q < VALUE_END;
  assign frame_clr = advance && last;

  asrp_code_field u_code (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (code_en),
    .clr_i    (frame_clr),
    .byte_i   (in_byte_q),
    .code_d_o (code_d)
  );

  asrp_value_field u_value (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (value_en),
    .clr_i     (frame_clr),
    .byte_i    (in_byte_q),
    .value_d_o (value_d)
  );

  // Record formed from the parser next state so a last byte inside the
  // value field is included.
  assign bad_code = (code_d.neg && code_d.acc != '0) || (code_d.acc > max_code_q);

  always_comb begin
    mant_signed = $signed({1'b0, value_d.mant});
    if (value_d.neg) begin
      mant_signed = -$signed({1'b0, value_d.mant});
    end
    if (bad_code) begin
      status_d = ST_BAD_CODE;
    end else if (!value_d.digit) begin
      status_d = ST_NO_NUMBER;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_code_q <= MAX_CODE_RST;
    end else if (max_code_we_i) begin
      max_code_q <= max_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pos_q      <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= rx_i.valid;
      end
      if (advance) begin
        pos_q <= last ? '0 : pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_clr) begin
      out_valid_q <= 1'b1;
    end else if (rec_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_clr) begin
      code_q   <= code_d.acc;
      status_q <= status_d;
      if (status_d == ST_OK) begin
        mant_q <= mant_signed;
        frac_q <= value_d.frac;
      end else begin
        mant_q <= '0;
        frac_q <= '0;
      end
    end
  end

  assign rec_o.valid           = out_valid_q;
  assign rec_o.channel_code    = code_q;
  assign rec_o.value_mantissa  = mant_q;
  assign rec_o.fraction_digits = frac_q;
  assign rec_o.status          = status_q;

endmodule

`default_nettype wire

FILE: sv/asrp_code_field.sv
// Channel code field parser (atoi rules, saturating 7-bit accumulator).
// Depends on asrp_pkg.
`default_nettype none

module asrp_code_field (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 clr_i,
  input  logic [7:0]           byte_i,
  output asrp_pkg::code_t      code_d_o
);
  import asrp_pkg::*;

  logic [CODE_W-1:0] acc_q, acc_d;
  logic              started_q, started_d;
  logic              neg_q, neg_d;
  logic              stop_q, stop_d;
  logic [10:0]       prod;

  // acc * 10 + digit
  assign prod = 11'({acc_q, 3'b000}) + 11'({acc_q, 1'b0}) + 11'(byte_i[3:0]);

  always_comb begin
    acc_d     = acc_q;
    started_d = started_q;
    neg_d     = neg_q;
    stop_d    = stop_q;
    if (en_i && !stop_q && !(!started_q && is_white(byte_i))) begin
      started_d = 1'b1;
      if (!started_q && byte_i == CHR_PLUS) begin
        neg_d = neg_q;
      end else if (!started_q && byte_i == CHR_MINUS) begin
        neg_d = 1'b1;
      end else if (is_digit(byte_i)) begin
        acc_d = (prod > 11'(CODE_SAT)) ? CODE_SAT : prod[CODE_W-1:0];
      end else begin
        stop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      started_q <= 1'b0;
      neg_q     <= 1'b0;
      stop_q    <= 1'b0;
    end else if (clr_i) begin
      acc_q     <= '0;
      started_q <= 1'b0;
      neg_q     <= 1'b0;
      stop_q    <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      started_q <= started_d;
      neg_q     <= neg_d;
      stop_q    <= stop_d;
    end
  end

  assign code_d_o.acc = acc_d;
  assign code_d_o.neg = neg_d;

endmodule

`default_nettype wire

FILE: sv/asrp_value_field.sv
// Value field parser: sign, digits and one decimal point, kept as mantissa
// plus fraction digit count. Depends on asrp_pkg.
`default_nettype none

module asrp_value_field (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 clr_i,
  input  logic [7:0]           byte_i,
  output asrp_pkg::value_t     value_d_o
);
  import asrp_pkg::*;

  logic [MANT_W-1:0] mant_q, mant_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic              started_q, started_d;
  logic              neg_q, neg_d;
  logic              point_q, point_d;
  logic              digit_q, digit_d;
  logic              stop_q, stop_d;
  logic [MANT_W+3:0] prod;

  assign prod = (MANT_W+4)'({mant_q, 3'b000}) + (MANT_W+4)'({mant_q, 1'b0})
              + (MANT_W+4)'(byte_i[3:0]);

  always_comb begin
    mant_d    = mant_q;
    frac_d    = frac_q;
    started_d = started_q;
    neg_d     = neg_q;
    point_d   = point_q;
    digit_d   = digit_q;
    stop_d    = stop_q;
    if (en_i && !stop_q && !(!started_q && is_white(byte_i))) begin
      started_d = 1'b1;
      if (!started_q && byte_i == CHR_PLUS) begin
        neg_d = neg_q;
      end else if (!started_q && byte_i == CHR_MINUS) begin
        neg_d = 1'b1;
      end else if (byte_i == CHR_POINT && !point_q) begin
        point_d = 1'b1;
      end else if (is_digit(byte_i)) begin
        mant_d  = (prod > (MANT_W+4)'(MANT_SAT)) ? MANT_SAT : prod[MANT_W-1:0];
        digit_d = 1'b1;
        if (point_q && frac_q < FRAC_MAX) begin
          frac_d = frac_q + 3'd1;
        end
      end else begin
        stop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mant_q    <= '0;
      frac_q    <= '0;
      started_q <= 1'b0;
      neg_q     <= 1'b0;
      point_q   <= 1'b0;
      digit_q   <= 1'b0;
      stop_q    <= 1'b0;
    end else if (clr_i) begin
      mant_q    <= '0;
      frac_q    <= '0;
      started_q <= 1'b0;
      neg_q     <= 1'b0;
      point_q   <= 1'b0;
      digit_q   <= 1'b0;
      stop_q    <= 1'b0;
    end else begin
      mant_q    <= mant_d;
      frac_q    <= frac_d;
      started_q <= started_d;
      neg_q     <= neg_d;
      point_q   <= point_d;
      digit_q   <= digit_d;
      stop_q    <= stop_d;
    end
  end

  assign value_d_o.mant  = mant_d;
  assign value_d_o.frac  = frac_d;
  assign value_d_o.neg   = neg_d;
  assign value_d_o.digit = digit_d;

endmodule

`default_nettype wire

FILE: sv/asrp_checker.sv
// Port-level checks for the ASCII sensor record parser, bound to the top level.
// Depends on asrp_pkg.
`default_nettype none

module asrp_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rx_valid_i,
  input  logic                            rx_ready_i,
  input  logic                            rec_valid_i,
  input  logic                            rec_ready_i,
  input  logic [asrp_pkg::CODE_W-1:0]     channel_code_i,
  input  logic signed [asrp_pkg::VALUE_W-1:0] value_mantissa_i,
  input  logic [asrp_pkg::FRAC_W-1:0]     fraction_digits_i,
  input  asrp_pkg::status_e               status_i
);
  import asrp_pkg::*;

  // a stalled record holds
  a_rec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i && !rec_ready_i |=> rec_valid_i && $stable(value_mantissa_i)
      && $stable(status_i) && $stable(channel_code_i))
    else $error("record changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i && status_i != ST_OK |-> value_mantissa_i == '0
      && fraction_digits_i == '0)
    else $error("error record carries a value");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i |-> channel_code_i <= 7'd99 && fraction_digits_i <= 3'd6)
    else $error("code or fraction count out of range");

  // a new record only follows an earlier byte transaction
  a_rec_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rec_valid_i) |-> $past(rx_valid_i && rx_ready_i, 2))
    else $error("record without a preceding byte");

endmodule

bind ascii_sensor_record_parser asrp_checker u_asrp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rx_valid_i        (rx_i.valid),
  .rx_ready_i        (rx_i.ready),
  .rec_valid_i       (rec_o.valid),
  .rec_ready_i       (rec_o.ready),
  .channel_code_i    (rec_o.channel_code),
  .value_mantissa_i  (rec_o.value_mantissa),
  .fraction_digits_i (rec_o.fraction_digits),
  .status_i          (rec_o.status)
);

`default_nettype wire
